// ===== rtl/msort_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package msort_pkg;

    localparam int unsigned DataWidth = 32;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RUN,
        ST_FETCH,
        ST_MERGE,
        ST_OUT_RD,
        ST_OUT_WR
    } t_seq_state;

    typedef struct packed {
        logic load_ready;
        logic rd_en;
        logic wr_en;
        logic wr_left;
        logic src_sel;
        logic out_load;
        logic out_last;
        logic done;
    } t_seq_ctl;

endpackage

`default_nettype wire

// ===== rtl/msort_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msort_seq #(
    parameter int unsigned CW = 5,
    parameter int unsigned AW = 4
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_start,
    input  wire [CW-1:0]           i_n,
    input  wire                    i_a_le_b,
    input  wire                    i_out_free,
    output msort_pkg::t_seq_ctl    o_ctl,
    output logic [AW-1:0]          o_rd_a_addr,
    output logic [AW-1:0]          o_rd_b_addr,
    output logic [AW-1:0]          o_wr_addr
);

    msort_pkg::t_seq_state r_state, n_state;

    logic [CW-1:0] r_n, n_n;
    logic [CW:0]   r_w, n_w;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_mid, n_mid;
    logic [CW-1:0] r_hi, n_hi;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_k, n_k;
    logic          r_src, n_src;

    logic [CW+1:0] sum_mid;
    logic [CW+1:0] sum_hi;
    logic [CW+1:0] n_ext;
    logic [CW-1:0] run_mid;
    logic [CW-1:0] run_hi;
    logic [CW-1:0] k_inc;
    logic [CW:0]   w2;
    logic          left_ok;
    logic          right_ok;
    logic          take_left;
    logic          run_end;
    logic          pass_end;
    logic          sort_end;
    logic          out_end;

    assign sum_mid   = {2'b00, r_lo} + {1'b0, r_w};
    assign sum_hi    = {2'b00, r_lo} + {r_w, 1'b0};
    assign n_ext     = {2'b00, r_n};
    assign run_mid   = (sum_mid > n_ext) ? r_n : sum_mid[CW-1:0];
    assign run_hi    = (sum_hi > n_ext) ? r_n : sum_hi[CW-1:0];
    assign k_inc     = r_k + CW'(1);
    assign w2        = {r_w[CW-1:0], 1'b0};
    assign left_ok   = r_i < r_mid;
    assign right_ok  = r_j < r_hi;
    assign take_left = left_ok && (!right_ok || i_a_le_b);
    assign run_end   = k_inc == r_hi;
    assign pass_end  = sum_hi >= n_ext;
    assign sort_end  = w2 >= {1'b0, r_n};
    assign out_end   = k_inc == r_n;

    always_comb begin
        n_state = r_state;
        case (r_state)
            msort_pkg::ST_LOAD: begin
                if (i_start) begin
                    n_state = (i_n <= CW'(1)) ? msort_pkg::ST_OUT_RD : msort_pkg::ST_RUN;
                end
            end
            msort_pkg::ST_RUN: begin
                n_state = msort_pkg::ST_FETCH;
            end
            msort_pkg::ST_FETCH: begin
                n_state = msort_pkg::ST_MERGE;
            end
            msort_pkg::ST_MERGE: begin
                if (!run_end) begin
                    n_state = msort_pkg::ST_FETCH;
                end else if (pass_end && sort_end) begin
                    n_state = msort_pkg::ST_OUT_RD;
                end else begin
                    n_state = msort_pkg::ST_RUN;
                end
            end
            msort_pkg::ST_OUT_RD: begin
                if (i_out_free) begin
                    n_state = msort_pkg::ST_OUT_WR;
                end
            end
            msort_pkg::ST_OUT_WR: begin
                n_state = out_end ? msort_pkg::ST_LOAD : msort_pkg::ST_OUT_RD;
            end
            default: begin
                n_state = msort_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb begin
        o_ctl            = '0;
        o_ctl.load_ready = r_state == msort_pkg::ST_LOAD;
        o_ctl.rd_en      = (r_state == msort_pkg::ST_FETCH)
                        || ((r_state == msort_pkg::ST_OUT_RD) && i_out_free);
        o_ctl.wr_en      = r_state == msort_pkg::ST_MERGE;
        o_ctl.wr_left    = take_left;
        o_ctl.src_sel    = r_src;
        o_ctl.out_load   = r_state == msort_pkg::ST_OUT_WR;
        o_ctl.out_last   = out_end;
        o_ctl.done       = (r_state == msort_pkg::ST_OUT_WR) && out_end;
        o_rd_a_addr      = (r_state == msort_pkg::ST_FETCH) ? r_i[AW-1:0] : r_k[AW-1:0];
        o_rd_b_addr      = r_j[AW-1:0];
        o_wr_addr        = r_k[AW-1:0];
    end

    always_comb begin
        n_n   = r_n;
        n_w   = r_w;
        n_lo  = r_lo;
        n_mid = r_mid;
        n_hi  = r_hi;
        n_i   = r_i;
        n_j   = r_j;
        n_k   = r_k;
        n_src = r_src;
        case (r_state)
            msort_pkg::ST_LOAD: begin
                if (i_start) begin
                    n_n   = i_n;
                    n_w   = (CW+1)'(1);
                    n_lo  = '0;
                    n_k   = '0;
                    n_src = 1'b0;
                end
            end
            msort_pkg::ST_RUN: begin
                n_mid = run_mid;
                n_hi  = run_hi;
                n_i   = r_lo;
                n_j   = run_mid;
                n_k   = r_lo;
            end
            msort_pkg::ST_MERGE: begin
                if (take_left) begin
                    n_i = r_i + CW'(1);
                end else begin
                    n_j = r_j + CW'(1);
                end
                n_k = k_inc;
                if (run_end) begin
                    if (pass_end) begin
                        n_w   = w2;
                        n_src = ~r_src;
                        n_lo  = '0;
                        n_k   = '0;
                    end else begin
                        n_lo = sum_hi[CW-1:0];
                    end
                end
            end
            msort_pkg::ST_OUT_WR: begin
                n_k = k_inc;
            end
            default: begin
                n_k = r_k;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= msort_pkg::ST_LOAD;
            r_n     <= '0;
            r_w     <= '0;
            r_lo    <= '0;
            r_mid   <= '0;
            r_hi    <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_src   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_w     <= n_w;
            r_lo    <= n_lo;
            r_mid   <= n_mid;
            r_hi    <= n_hi;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_src   <= n_src;
        end
    end

    a_read_stays_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == msort_pkg::ST_MERGE) |-> (r_k < r_hi) && (r_hi <= r_n))
        else $error("merge output index left its run");

    a_one_side_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == msort_pkg::ST_MERGE) |-> (left_ok || right_ok))
        else $error("merge step with both runs exhausted");

    a_index_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == msort_pkg::ST_MERGE)
        |-> ({1'b0, r_k} + {1'b0, r_mid} == {1'b0, r_i} + {1'b0, r_j}))
        else $error("merge indices out of step");

endmodule

`default_nettype wire

// ===== rtl/merge_sorter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  tdata              tlast        tuser
// s_axis    in         value[31:0]        is_last      -
// m_axis    out        sorted_value[31:0] end_of_list  truncated
//
// Loading takes one cycle per element; the last element starts the sort.
// The sort makes ceil(log2 N) merge passes, as one compare unit alternates
// between the two stores; output reads each result through the store read port.
// Reset is synchronous and active low; the input is held off from the last
// transfer until the final result has been loaded, and m_axis stalls are absorbed.

module merge_sorter_unit #(
    parameter int unsigned MAX_ELEMENTS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // value[31:0]
    input  wire         s_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,   // sorted_value[31:0]
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // truncated
);

    localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
    localparam int unsigned AW = $clog2(MAX_ELEMENTS);
    localparam int unsigned DW = msort_pkg::DataWidth;

    logic [DW-1:0] r_list_store [MAX_ELEMENTS];
    logic [DW-1:0] r_merge_scratch [MAX_ELEMENTS];

    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic [DW-1:0] r_rd_a;
    logic [DW-1:0] r_rd_b;
    logic          r_out_valid;
    logic [DW-1:0] r_out_data;
    logic          r_out_last;
    logic          r_out_trunc;

    msort_pkg::t_seq_ctl seq_ctl;
    logic [AW-1:0] rd_a_addr;
    logic [AW-1:0] rd_b_addr;
    logic [AW-1:0] wr_addr;
    logic          in_acc;
    logic          has_room;
    logic          load_we;
    logic          start;
    logic [CW-1:0] n_in;
    logic          a_le_b;
    logic          out_free;
    logic [DW-1:0] wr_data;

    assign s_axis_tready = seq_ctl.load_ready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign has_room      = r_count < CW'(MAX_ELEMENTS);
    assign load_we       = in_acc && has_room;
    assign start         = in_acc && s_axis_tlast;
    assign n_in          = has_room ? (r_count + CW'(1)) : r_count;
    assign a_le_b        = $signed(r_rd_a) <= $signed(r_rd_b);
    assign out_free      = !r_out_valid || m_axis_tready;
    assign wr_data       = seq_ctl.wr_left ? r_rd_a : r_rd_b;

    msort_seq #(
        .CW           (CW),
        .AW           (AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_n         (n_in),
        .i_a_le_b    (a_le_b),
        .i_out_free  (out_free),
        .o_ctl       (seq_ctl),
        .o_rd_a_addr (rd_a_addr),
        .o_rd_b_addr (rd_b_addr),
        .o_wr_addr   (wr_addr)
    );

    always_ff @(posedge i_clk) begin
        if (load_we) begin
            r_list_store[r_count[AW-1:0]] <= s_axis_tdata;
        end else if (seq_ctl.wr_en && seq_ctl.src_sel) begin
            r_list_store[wr_addr] <= wr_data;
        end
        if (seq_ctl.wr_en && !seq_ctl.src_sel) begin
            r_merge_scratch[wr_addr] <= wr_data;
        end
        if (seq_ctl.rd_en) begin
            r_rd_a <= seq_ctl.src_sel ? r_merge_scratch[rd_a_addr] : r_list_store[rd_a_addr];
            r_rd_b <= seq_ctl.src_sel ? r_merge_scratch[rd_b_addr] : r_list_store[rd_b_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (seq_ctl.done) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else if (load_we) begin
                r_count <= r_count + CW'(1);
            end else if (in_acc) begin
                r_ovf <= 1'b1;
            end
            if (seq_ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_ctl.out_load) begin
            r_out_data  <= r_rd_a;
            r_out_last  <= seq_ctl.out_last;
            r_out_trunc <= r_ovf;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_trunc;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ELEMENTS))
        else $error("element count beyond store depth");

    a_single_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(load_we && seq_ctl.wr_en))
        else $error("load and merge write the store together");

    a_write_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_ctl.wr_en |-> $past(seq_ctl.rd_en))
        else $error("merge write without a preceding read");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_ctl.out_load |-> $past(out_free))
        else $error("result register overwritten before transfer");

    a_clear_after_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_ctl.done |=> (r_count == '0) && !r_ovf)
        else $error("list state not cleared after output");

endmodule

`default_nettype wire
